>>> rtl/scan_polar_to_cartesian_wall_filter_top_assert.svh
// Assertion macros for the scan polar to cartesian wall filter block.
`ifndef SCAN_POLAR_TO_CARTESIAN_WALL_FILTER_TOP_ASSERT_SVH
`define SCAN_POLAR_TO_CARTESIAN_WALL_FILTER_TOP_ASSERT_SVH

// Property that is checked only while the block is out of reset.
`define SPCWF_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Property that is checked at every edge, reset cycles included.
`define SPCWF_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/spcwf_pkg.sv
// Shared types, constants and the sine table generator for the scan converter.
package spcwf_pkg;

  // Fixed field widths of the request and point channels.
  localparam int RANGE_W = 16;
  localparam int COORD_W = 17;
  localparam int ANGLE_W = 9;
  localparam int THRESH_W = 18;

  // Trig angle bookkeeping: degrees in one quadrant.
  localparam int QUARTER_STEPS = 90;
  localparam int REM_W = 7;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 17;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Constants of the fixed-point sine series.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] DEG_HALF_TURN = 64'd180;
  localparam int SERIES_TERMS = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WALL_FILTER_ENABLE = 2'd0,
    REG_WALL_BOUNDARY      = 2'd1,
    REG_WALL_TOLERANCE     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quad_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic [RANGE_W-1:0] range_sample;
    quad_t              quad;
    logic [REM_W-1:0]   rem;
    logic [ANGLE_W-1:0] angle_degrees;
  } spcwf_item_t;

  // Unsigned 64-bit quotient by shift and subtract; it is evaluated only
  // while the sine table is built at elaboration.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] part;
    quo = '0;
    part = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[63:0], num[i]};
      if (part >= {1'b0, den}) begin
        part = part - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine of d whole degrees (0 to 90) with fb fraction bits, evaluated at
  // elaboration as a truncated Taylor series in Q30, rounded half up and
  // clamped to one.
  function automatic logic [63:0] quarter_sine(input int unsigned d, input int unsigned fb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] one;
    logic [63:0] r;
    logic [63:0] div;
    x = div_u64(64'(d) * PI_Q30, DEG_HALF_TURN);
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    one = 64'd1 << fb;
    for (int k = 1; k < SERIES_TERMS; k++) begin
      div = 64'(2 * k) * 64'(2 * k + 1);
      term = (term * x2) >> 30;
      term = div_u64(term, div);
      if (k % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + (64'd1 << (29 - fb))) >> (30 - fb);
    return (r > one) ? one : r;
  endfunction

endpackage

>>> rtl/spcwf_ifs.sv
// Valid/ready channel interfaces for range samples and cartesian points.
interface spcwf_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_sample;
  logic        scan_start;

  modport source (output valid, output range_sample, output scan_start, input ready);
  modport sink (input valid, input range_sample, input scan_start, output ready);
endinterface

interface spcwf_point_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] point_x;
  logic signed [16:0] point_y;
  logic [8:0]         angle_degrees;

  modport source (output valid, output point_x, output point_y, output angle_degrees,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input angle_degrees,
                output ready);
endinterface

>>> rtl/spcwf_front.sv
// Front end: accepts samples, tracks the beam angle and splits it into quadrant terms.
module spcwf_front #(
  parameter int ANGLE_STEPS = 360
) (
  input  logic                     clk,
  input  logic                     rst,
  spcwf_sample_if.sink             sample,
  output logic                     push_valid,
  input  logic                     push_ready,
  output spcwf_pkg::spcwf_item_t   push_item
);
  import spcwf_pkg::*;

  localparam int CW = $clog2(ANGLE_STEPS);
  localparam logic [CW-1:0] LAST_ANGLE = CW'(ANGLE_STEPS - 1);
  localparam logic [REM_W-1:0] LAST_REM = REM_W'(QUARTER_STEPS - 1);

  logic [CW-1:0]    angle_counter;
  logic [CW-1:0]    angle_counter_next;
  quad_t            quad;
  quad_t            quad_next;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_next;

  logic [CW-1:0]    angle_cur;
  quad_t            quad_cur;
  logic [REM_W-1:0] rem_cur;
  logic [CW+8:0]    angle_wide;
  logic             accept;

  // The queue decides whether a request can be taken.
  assign sample.ready = push_ready;
  assign push_valid = sample.valid;
  assign accept = sample.valid && push_ready;

  // A scan start forces the beam to angle zero.
  always_comb begin
    angle_cur = sample.scan_start ? '0 : angle_counter;
    quad_cur = sample.scan_start ? QUAD_FIRST : quad;
    rem_cur = sample.scan_start ? '0 : rem;
  end

  // Advance the counter and its quadrant split together, wrapping both at
  // the last angle step.
  always_comb begin
    if (angle_cur == LAST_ANGLE) begin
      angle_counter_next = '0;
      quad_next = QUAD_FIRST;
      rem_next = '0;
    end else if (rem_cur == LAST_REM) begin
      angle_counter_next = angle_cur + 1'b1;
      quad_next = quad_t'(quad_cur + 2'd1);
      rem_next = '0;
    end else begin
      angle_counter_next = angle_cur + 1'b1;
      quad_next = quad_cur;
      rem_next = rem_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_counter <= '0;
      quad <= QUAD_FIRST;
      rem <= '0;
    end else if (accept) begin
      angle_counter <= angle_counter_next;
      quad <= quad_next;
      rem <= rem_next;
    end
  end

  // The reported angle keeps the low bits of the counter.
  assign angle_wide = {9'd0, angle_cur};

  always_comb begin
    push_item.range_sample = sample.range_sample;
    push_item.quad = quad_cur;
    push_item.rem = rem_cur;
    push_item.angle_degrees = angle_wide[ANGLE_W-1:0];
  end

endmodule

>>> rtl/spcwf_queue.sv
// Two-entry queue that decouples the front end from the back end.
module spcwf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  spcwf_pkg::spcwf_item_t in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output spcwf_pkg::spcwf_item_t out_item
);
  import spcwf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  spcwf_item_t      entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_item = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

>>> rtl/spcwf_back.sv
// Back end: sine table lookup, range scaling, wall filter and output register.
module spcwf_back #(
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  spcwf_pkg::spcwf_item_t item,
  input  logic                   filter_enable,
  input  logic signed [17:0]     wall_threshold,
  spcwf_point_if.source          point
);
  import spcwf_pkg::*;

  localparam int MW = TRIG_FRACTION_BITS + 1;
  localparam int PW = RANGE_W + MW;

  typedef logic [MW-1:0] sine_tab_t [0:QUARTER_STEPS];

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int i = 0; i <= QUARTER_STEPS; i++) begin
      t[i] = MW'(quarter_sine(i, TRIG_FRACTION_BITS));
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic               adv;
  logic [REM_W-1:0]   rem_c;
  logic [MW-1:0]      s_r;
  logic [MW-1:0]      s_c;
  logic [MW-1:0]      smag;
  logic [MW-1:0]      cmag;
  logic               sneg;
  logic               cneg;

  logic               s1_valid;
  logic [RANGE_W-1:0] s1_range;
  logic [MW-1:0]      s1_smag;
  logic [MW-1:0]      s1_cmag;
  logic               s1_sneg;
  logic               s1_cneg;
  logic [ANGLE_W-1:0] s1_angle;

  logic [PW-1:0]      prod_x;
  logic [PW-1:0]      prod_y;

  logic               s2_valid;
  logic [RANGE_W-1:0] s2_px;
  logic [RANGE_W-1:0] s2_py;
  logic               s2_sneg;
  logic               s2_cneg;
  logic [ANGLE_W-1:0] s2_angle;

  logic [COORD_W-1:0] x_val;
  logic [COORD_W-1:0] y_val;
  logic               keep;

  // The whole pipeline moves when the output register is free or drains.
  assign adv = !point.valid || point.ready;
  assign item_ready = adv;

  // Table lookups for the reduced angle and its complement.
  assign rem_c = REM_W'(QUARTER_STEPS) - item.rem;
  assign s_r = SINE_TAB[item.rem];
  assign s_c = SINE_TAB[rem_c];

  // Quadrant symmetry picks magnitudes and signs.
  always_comb begin
    case (item.quad)
      QUAD_FIRST: begin
        smag = s_r; sneg = 1'b0; cmag = s_c; cneg = 1'b0;
      end
      QUAD_SECOND: begin
        smag = s_c; sneg = 1'b0; cmag = s_r; cneg = 1'b1;
      end
      QUAD_THIRD: begin
        smag = s_r; sneg = 1'b1; cmag = s_c; cneg = 1'b1;
      end
      default: begin
        smag = s_c; sneg = 1'b1; cmag = s_r; cneg = 1'b0;
      end
    endcase
  end

  // Range times trig magnitude, truncated to range units.
  assign prod_x = PW'(s1_range) * PW'(s1_cmag);
  assign prod_y = PW'(s1_range) * PW'(s1_smag);

  // Signed coordinates and the wall test.
  always_comb begin
    x_val = s2_cneg ? -{1'b0, s2_px} : {1'b0, s2_px};
    y_val = s2_sneg ? -{1'b0, s2_py} : {1'b0, s2_py};
    keep = !filter_enable || ($signed({y_val[COORD_W-1], y_val}) > wall_threshold);
  end

  // Stage valid flags and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      point.valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
      point.valid <= s2_valid && keep;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_range <= item.range_sample;
      s1_smag <= smag;
      s1_cmag <= cmag;
      s1_sneg <= sneg;
      s1_cneg <= cneg;
      s1_angle <= item.angle_degrees;

      s2_px <= prod_x[TRIG_FRACTION_BITS +: RANGE_W];
      s2_py <= prod_y[TRIG_FRACTION_BITS +: RANGE_W];
      s2_sneg <= s1_sneg;
      s2_cneg <= s1_cneg;
      s2_angle <= s1_angle;

      point.point_x <= $signed(x_val);
      point.point_y <= $signed(y_val);
      point.angle_degrees <= s2_angle;
    end
  end

endmodule

>>> rtl/scan_polar_to_cartesian_wall_filter_top.sv
// Converts laser range samples, one per degree step, into cartesian points
// x = range*cos(angle) and y = range*sin(angle), using a fixed-point sine
// table with TRIG_FRACTION_BITS fraction bits and truncating toward zero.
// A scan start flag puts the beam at angle zero; otherwise the angle steps
// by one and wraps at ANGLE_STEPS. With the wall filter on, only points whose
// y is strictly above wall_boundary - wall_tolerance come out. One request is
// taken every cycle while the queue has room: the front end steps the angle
// counter on each accepted request, and the back end is a three-register
// pipeline (table lookup, multiply, sign and filter) that finishes one point
// per cycle while the point channel does not stall. A two-entry queue
// between the halves holds requests and absorbs stalls on the point channel.
// The user must write configuration only while the block is idle; the block does not enforce it.
`include "scan_polar_to_cartesian_wall_filter_top_assert.svh"

module scan_polar_to_cartesian_wall_filter_top #(
  parameter int ANGLE_STEPS = 360,
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  spcwf_sample_if.sink                       sample,
  spcwf_point_if.source                      point,
  input  logic                               cfg_we,
  input  logic [spcwf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [spcwf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spcwf_pkg::*;

  logic                       wall_filter_enable;
  logic signed [COORD_W-1:0]  wall_boundary;
  logic [RANGE_W-1:0]         wall_tolerance;
  logic signed [THRESH_W-1:0] wall_threshold;

  logic        push_valid;
  logic        push_ready;
  spcwf_item_t push_item;
  logic        q_valid;
  logic        q_ready;
  spcwf_item_t q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_filter_enable <= 1'b0;
      wall_boundary <= '0;
      wall_tolerance <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_WALL_FILTER_ENABLE: wall_filter_enable <= cfg_data[0];
        REG_WALL_BOUNDARY:      wall_boundary <= $signed(cfg_data[COORD_W-1:0]);
        REG_WALL_TOLERANCE:     wall_tolerance <= cfg_data[RANGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Filter threshold: boundary minus tolerance, one bit wider.
  assign wall_threshold = $signed({wall_boundary[COORD_W-1], wall_boundary})
                        - $signed({2'b00, wall_tolerance});

  spcwf_front #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  spcwf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_item   (push_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  spcwf_back #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (q_valid),
    .item_ready     (q_ready),
    .item           (q_item),
    .filter_enable  (wall_filter_enable),
    .wall_threshold (wall_threshold),
    .point          (point)
  );

  // Every point that leaves with the filter on lies above the threshold.
  `SPCWF_CHECK(a_wall_filter, point.valid && wall_filter_enable |-> ($signed({point.point_y[COORD_W-1], point.point_y}) > wall_threshold), "point below wall threshold was emitted")

  // A beam at angle zero lies on the positive x axis.
  `SPCWF_CHECK(a_zero_angle, (ANGLE_STEPS <= 360) && point.valid && point.angle_degrees == 9'd0 |-> point.point_y == 17'sd0 && !point.point_x[COORD_W-1], "angle zero point off the x axis")

  // A beam at ninety degrees lies on the y axis.
  `SPCWF_CHECK(a_right_angle, (ANGLE_STEPS <= 360) && point.valid && point.angle_degrees == 9'd90 |-> point.point_x == 17'sd0, "ninety degree point off the y axis")

  // Reset empties the pipeline and opens the request side.
  `SPCWF_CHECK_ALWAYS(a_reset_clears, rst |=> !point.valid && sample.ready, "reset left the block busy")

endmodule

>>> tb/spcwf_point_checker.sv
// Watches the sample and point channels, predicts every point and compares it.
`timescale 1ns / 1ps

module spcwf_point_checker
  import spcwf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  spcwf_sample_if                samples,
  spcwf_point_if                 points,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int FRAC_BITS = 15;
  localparam int BEAM_STEPS = 360;
  localparam int SERIES_LEN = 12;
  localparam longint unsigned PI_FIXED = 64'd3373259426;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ANGLE_W-1:0]        deg;
  } point_t;

  longint unsigned sine_tab [0:90];
  point_t          expected_points [$];
  logic [ANGLE_W-1:0] next_beam;
  logic            filter_on;
  int              wall_pos;
  int              wall_margin;
  int              mismatches;

  // Sine of a whole degree in the first quadrant, unsigned with FRAC_BITS
  // fraction bits, from a Q30 Taylor series with every term truncated.
  function automatic longint unsigned first_quadrant_sine(input int unsigned deg);
    longint unsigned arg;
    longint unsigned arg_sq;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned rounded;
    arg = (64'(deg) * PI_FIXED) / 64'd180;
    arg_sq = (arg * arg) >> 30;
    term = arg;
    acc = arg;
    for (int k = 1; k < SERIES_LEN; k++) begin
      term = (term * arg_sq) >> 30;
      term = term / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    rounded = (acc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return (rounded > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : rounded;
  endfunction

  // Cartesian point of one beam; magnitudes are truncated before the sign.
  function automatic point_t polar_to_point(input logic [RANGE_W-1:0] range_val,
                                            input logic [ANGLE_W-1:0] deg);
    quad_t           quad;
    int unsigned     rem;
    longint unsigned sin_mag;
    longint unsigned cos_mag;
    logic            sin_neg;
    logic            cos_neg;
    longint          px;
    longint          py;
    point_t          p;
    quad = quad_t'(2'(deg / 90));
    rem = deg % 90;
    case (quad)
      QUAD_FIRST: begin
        sin_mag = sine_tab[rem]; cos_mag = sine_tab[90 - rem];
        sin_neg = 1'b0; cos_neg = 1'b0;
      end
      QUAD_SECOND: begin
        sin_mag = sine_tab[90 - rem]; cos_mag = sine_tab[rem];
        sin_neg = 1'b0; cos_neg = 1'b1;
      end
      QUAD_THIRD: begin
        sin_mag = sine_tab[rem]; cos_mag = sine_tab[90 - rem];
        sin_neg = 1'b1; cos_neg = 1'b1;
      end
      default: begin
        sin_mag = sine_tab[90 - rem]; cos_mag = sine_tab[rem];
        sin_neg = 1'b1; cos_neg = 1'b0;
      end
    endcase
    px = longint'((64'(range_val) * cos_mag) >> FRAC_BITS);
    py = longint'((64'(range_val) * sin_mag) >> FRAC_BITS);
    if (cos_neg) begin
      px = -px;
    end
    if (sin_neg) begin
      py = -py;
    end
    p.x = COORD_W'(px);
    p.y = COORD_W'(py);
    p.deg = deg;
    return p;
  endfunction

  // The sine table is fixed for the whole run.
  initial begin
    for (int d = 0; d <= 90; d++) begin
      sine_tab[d] = first_quadrant_sine(d);
    end
  end

  // Track the registers, predict each accepted request and check each point.
  always @(posedge clk) begin
    logic [ANGLE_W-1:0] beam;
    point_t             want;
    point_t             got;
    if (rst) begin
      next_beam = '0;
      filter_on = 1'b0;
      wall_pos = 0;
      wall_margin = 0;
      mismatches = 0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WALL_FILTER_ENABLE: filter_on = cfg_data[0];
          REG_WALL_BOUNDARY:      wall_pos = $signed(cfg_data[COORD_W-1:0]);
          REG_WALL_TOLERANCE:     wall_margin = int'(cfg_data[15:0]);
          default: ;
        endcase
      end

      if (samples.valid && samples.ready) begin
        beam = samples.scan_start ? '0 : next_beam;
        if (beam >= BEAM_STEPS) begin
          beam = '0;
        end
        next_beam = (beam + 1 >= BEAM_STEPS) ? '0 : beam + 1'b1;
        want = polar_to_point(samples.range_sample, beam);
        if (!filter_on || (int'(want.y) > wall_pos - wall_margin)) begin
          expected_points = {expected_points, want};
        end
      end

      if (points.valid && points.ready) begin
        got.x = points.point_x;
        got.y = points.point_y;
        got.deg = points.angle_degrees;
        if (expected_points.size() == 0) begin
          $error("unexpected point: x %0d y %0d angle %0d", got.x, got.y, got.deg);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x) begin
            $error("point_x: expected %0d, actual %0d", want.x, got.x);
            mismatches++;
          end
          if (got.y !== want.y) begin
            $error("point_y: expected %0d, actual %0d", want.y, got.y);
            mismatches++;
          end
          if (got.deg !== want.deg) begin
            $error("angle_degrees: expected %0d, actual %0d", want.deg, got.deg);
            mismatches++;
          end
        end
      end
    end
    pending <= expected_points.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/tb.sv
// Top of the testbench: clock, reset, sample and register stimulus, verdict.
`timescale 1ns / 1ps

module tb;
  import spcwf_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 10;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;
  int                     idle_pct;
  int                     stall_pct;

  spcwf_sample_if sample_ch ();
  spcwf_point_if  point_ch ();

  scan_polar_to_cartesian_wall_filter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .point     (point_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spcwf_point_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .samples    (sample_ch),
    .points     (point_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // The point receiver stalls at random.
  always @(posedge clk) begin
    point_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one sample request and hold it until it is taken.
  task automatic send_sample(input logic [RANGE_W-1:0] range_val, input logic start_val);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.range_sample <= range_val;
    sample_ch.scan_start <= start_val;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Stop sending, let every expected point arrive and the pipeline settle.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers and the spare index in back-to-back cycles.
  task automatic write_config(input logic [CFG_DATA_W-1:0] en_word,
                              input logic [CFG_DATA_W-1:0] bound_word,
                              input logic [CFG_DATA_W-1:0] tol_word);
    cfg_we <= 1'b1;
    cfg_index <= REG_WALL_FILTER_ENABLE;
    cfg_data <= en_word;
    @(posedge clk);
    cfg_index <= REG_WALL_BOUNDARY;
    cfg_data <= bound_word;
    @(posedge clk);
    cfg_index <= REG_WALL_TOLERANCE;
    cfg_data <= tol_word;
    @(posedge clk);
    cfg_index <= CFG_INDEX_SPARE;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    return RANGE_W'($urandom);
  endfunction

  initial begin
    int budget;
    int sent;
    int scan_len;
    logic first_start;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_WALL_FILTER_ENABLE;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.range_sample = '0;
    sample_ch.scan_start = 1'b0;
    point_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a first sample without a start flag, range extremes and
    // alternating bit patterns, repeated start flags.
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);

    // Directed: wall threshold of zero, points exactly on it are dropped.
    drain();
    write_config(17'h1FFFF, 17'h00001, 17'h10001);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);

    // Random phases, each with a register setting and an idle and stall mode.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: write_config({16'($urandom), 1'b0}, 17'h00000, 17'h00000);
        1: write_config(17'h00001, 17'h00000, 17'h00000);
        2: write_config(17'h00001, 17'h0FFFF, 17'h00000);
        3: write_config(17'h00001, 17'h10000, 17'h0FFFF);
        4: write_config(17'h00001, 17'h0FFFF, 17'h1FFFF);
        default: write_config(17'($urandom), 17'($urandom), 17'($urandom));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      budget = (ph == 0) ? 400 : 65;
      sent = 0;
      while (sent < budget) begin
        // The first scan of the run goes past a full turn to show the wrap.
        if (ph == 0 && sent == 0) begin
          scan_len = 365;
          first_start = 1'b1;
        end else begin
          scan_len = $urandom_range(1, 60);
          first_start = ($urandom_range(99) < 85);
        end
        for (int i = 0; i < scan_len && sent < budget; i++) begin
          if (i == 0) begin
            send_sample(pick_range(), first_start);
          end else begin
            send_sample(pick_range(), $urandom_range(99) < 3);
          end
          sent++;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/spcwf_pkg.sv
rtl/spcwf_ifs.sv
rtl/spcwf_front.sv
rtl/spcwf_queue.sv
rtl/spcwf_back.sv
rtl/scan_polar_to_cartesian_wall_filter_top.sv
tb/spcwf_point_checker.sv
tb/tb.sv
